// ----- src/iokd_pkg.sv -----
// Package with the codes, constants and field types of the I/O port keyboard decoder.
`timescale 1ns / 1ps

package iokd_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 6;
  localparam int InDataWidth   = 96;
  localparam int OutDataWidth  = 40;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SOUND_KIND       = 3'd0,
    CFG_NTSC_MODE        = 3'd1,
    CFG_COLOUR_SUPPORTED = 3'd2,
    CFG_RAM_KILOBYTES    = 3'd3,
    CFG_LOW_RAM_ENABLED  = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    SOUND_NONE       = 2'd0,
    SOUND_VSYNC_BEEP = 2'd1,
    SOUND_SYNC_BEEP  = 2'd2,
    SOUND_CHIP       = 2'd3
  } sound_kind_t;

  typedef enum logic [1:0] {
    BEEP_NONE = 2'd0,
    BEEP_LOW  = 2'd1,
    BEEP_HIGH = 2'd2
  } beeper_event_t;

  typedef enum logic [2:0] {
    ACCESS_UNCHANGED = 3'd0,
    ACCESS_READ_FE   = 3'd1,
    ACCESS_WRITE_FD  = 3'd2,
    ACCESS_WRITE_FE  = 3'd3,
    ACCESS_WRITE_FF  = 3'd4
  } access_kind_t;

  typedef enum logic [1:0] {
    COLOUR_NONE    = 2'd0,
    COLOUR_ENABLE  = 2'd1,
    COLOUR_DISABLE = 2'd2
  } colour_event_t;

  localparam logic [7:0] COLOUR_PORT_HIGH = 8'h7f;
  localparam logic [7:0] COLOUR_PORT_LOW  = 8'hef;
  localparam logic [7:0] READ_IDLE        = 8'hff;
  localparam logic [7:0] COLOUR_PROBE_OK  = 8'h02;
  localparam logic [7:0] TAPE_BIT         = 8'h80;
  localparam logic [7:0] NTSC_BIT         = 8'h40;
  localparam logic [7:0] COLOUR_MODE_MASK = 8'h30;
  localparam logic [7:0] BORDER_MASK      = 8'h0f;
  localparam logic [7:0] PORT_CHIP_DATA_A = 8'h0f;
  localparam logic [7:0] PORT_CHIP_DATA_B = 8'h1f;
  localparam logic [7:0] PORT_CHIP_SEL_A  = 8'hbf;
  localparam logic [7:0] PORT_CHIP_SEL_B  = 8'hcf;
  localparam logic [7:0] PORT_CHIP_SEL_C  = 8'hdf;
  localparam logic [7:0] PORT_FD          = 8'hfd;
  localparam logic [7:0] PORT_FE          = 8'hfe;
  localparam logic [5:0] COLOUR_MIN_KB    = 6'd48;
  localparam logic [5:0] RAM_RESET_KB     = 6'd16;
  localparam logic [3:0] BORDER_RESET     = 4'hf;

  typedef struct packed {
    logic         frame_unsynced;
    logic         tape_level;
    logic         tape_active;
    logic [63:0]  key_rows;
    logic [7:0]   write_data;
    logic [7:0]   port_low;
    logic [7:0]   port_high;
  } in_fields_t;

  typedef struct packed {
    logic [3:0]   border_next;
    logic [1:0]   colour_event;
    logic [5:0]   colour_mode;
    logic [2:0]   access_kind;
    logic [7:0]   chip_data;
    logic [3:0]   chip_register;
    logic         chip_write;
    logic [1:0]   beeper_event;
    logic [7:0]   read_data;
  } out_fields_t;

endpackage

// ----- src/io_port_keyboard_decoder_top.sv -----
// I/O port keyboard decoder: decodes one port access per item into a result item.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; the single result register is refilled while it is taken.
// The item is decoded in one pass from the input ports into that result register.
// Reset (rst, synchronous): result empty, configuration to its defaults,
// sound register select and colour mode zero, pending border fifteen.
`timescale 1ns / 1ps

module io_port_keyboard_decoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [iokd_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [iokd_pkg::CfgDataWidth-1:0]   cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // port_high [7:0], port_low [15:8], write_data [23:16], key_rows [87:24],
  // tape_active [88], tape_level [89], frame_unsynced [90], zero [95:91]
  input  logic [iokd_pkg::InDataWidth-1:0]    s_axis_tdata,
  // mode [0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_data [7:0], beeper_event [9:8], chip_write [10], chip_register [14:11],
  // chip_data [22:15], access_kind [25:23], colour_mode [31:26],
  // colour_event [33:32], border_next [37:34], zero [39:38]
  output logic [iokd_pkg::OutDataWidth-1:0]   m_axis_tdata
);

  // Configuration registers
  iokd_pkg::sound_kind_t sound_kind;
  logic                  ntsc_mode;
  logic                  colour_supported;
  logic [5:0]            ram_kilobytes;
  logic                  low_ram_enabled;

  // Decoder state
  logic [3:0] sound_reg_select, sound_reg_select_next;
  logic [5:0] colour_mode_reg, colour_mode_reg_next;
  logic [3:0] border_pending, border_pending_next;

  iokd_pkg::in_fields_t  in_f;
  iokd_pkg::out_fields_t res, result;

  logic       accept;
  logic       colour_port;
  logic       beep_cond;
  logic       ram_ok;
  logic [7:0] row_and;
  logic [7:0] read_xor;
  logic [7:0] mode_bits;

  assign in_f          = iokd_pkg::in_fields_t'(s_axis_tdata[90:0]);
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tdata  = {2'b00, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_kind       <= iokd_pkg::SOUND_NONE;
      ntsc_mode        <= 1'b0;
      colour_supported <= 1'b0;
      ram_kilobytes    <= iokd_pkg::RAM_RESET_KB;
      low_ram_enabled  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iokd_pkg::CFG_SOUND_KIND:       sound_kind <= iokd_pkg::sound_kind_t'(cfg_data[1:0]);
        iokd_pkg::CFG_NTSC_MODE:        ntsc_mode <= cfg_data[0];
        iokd_pkg::CFG_COLOUR_SUPPORTED: colour_supported <= cfg_data[0];
        iokd_pkg::CFG_RAM_KILOBYTES:    ram_kilobytes <= cfg_data;
        iokd_pkg::CFG_LOW_RAM_ENABLED:  low_ram_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign colour_port = (in_f.port_high == iokd_pkg::COLOUR_PORT_HIGH) &&
                       (in_f.port_low == iokd_pkg::COLOUR_PORT_LOW);
  assign beep_cond   = (sound_kind == iokd_pkg::SOUND_VSYNC_BEEP) ||
                       ((sound_kind == iokd_pkg::SOUND_SYNC_BEEP) && in_f.frame_unsynced);
  assign ram_ok      = (ram_kilobytes >= iokd_pkg::COLOUR_MIN_KB) && low_ram_enabled;
  assign mode_bits   = in_f.write_data & iokd_pkg::COLOUR_MODE_MASK;

  // Every row whose select bit is low pulls its pressed keys into the result.
  always_comb begin
    row_and = 8'hff;
    for (int i = 0; i < 8; i++) begin
      if (!in_f.port_high[i]) begin
        row_and = row_and & in_f.key_rows[8*i +: 8];
      end
    end
  end

  always_comb begin
    if (in_f.tape_active) begin
      read_xor = (ntsc_mode ? iokd_pkg::NTSC_BIT : 8'h00) |
                 (in_f.tape_level ? 8'h00 : iokd_pkg::TAPE_BIT);
    end else begin
      read_xor = iokd_pkg::TAPE_BIT;
    end
  end

  always_comb begin
    sound_reg_select_next = sound_reg_select;
    colour_mode_reg_next  = colour_mode_reg;
    border_pending_next   = border_pending;
    res                   = '0;
    res.read_data         = iokd_pkg::READ_IDLE;
    res.beeper_event      = iokd_pkg::BEEP_NONE;
    res.access_kind       = iokd_pkg::ACCESS_UNCHANGED;
    res.colour_event      = iokd_pkg::COLOUR_NONE;
    if (!s_axis_tuser) begin
      if (colour_port) begin
        if (ram_ok && colour_supported) begin
          res.read_data = iokd_pkg::COLOUR_PROBE_OK;
        end
      end else if (!in_f.port_low[0]) begin
        res.access_kind = iokd_pkg::ACCESS_READ_FE;
        if (beep_cond) begin
          res.beeper_event = iokd_pkg::BEEP_LOW;
        end
        res.read_data = row_and ^ read_xor;
      end
    end else begin
      if (beep_cond) begin
        res.beeper_event = iokd_pkg::BEEP_HIGH;
      end
      if (colour_port) begin
        res.access_kind = iokd_pkg::ACCESS_WRITE_FF;
        if (colour_supported) begin
          if (mode_bits == 8'h00) begin
            res.colour_event     = iokd_pkg::COLOUR_DISABLE;
            colour_mode_reg_next = 6'd0;
          end else if (!ram_ok) begin
            // Colour asked for without enough memory or with low RAM disabled: the mode falls back to off silently.
            colour_mode_reg_next = 6'd0;
          end else begin
            res.colour_event     = iokd_pkg::COLOUR_ENABLE;
            colour_mode_reg_next = mode_bits[5:0];
            border_pending_next  = in_f.write_data[3:0];
          end
        end
      end else begin
        unique case (in_f.port_low)
          iokd_pkg::PORT_CHIP_DATA_A, iokd_pkg::PORT_CHIP_DATA_B: begin
            if (sound_kind == iokd_pkg::SOUND_CHIP) begin
              res.chip_write = 1'b1;
              res.chip_data  = in_f.write_data;
            end
          end
          iokd_pkg::PORT_CHIP_SEL_A, iokd_pkg::PORT_CHIP_SEL_B,
          iokd_pkg::PORT_CHIP_SEL_C: begin
            if (sound_kind == iokd_pkg::SOUND_CHIP) begin
              sound_reg_select_next = in_f.write_data[3:0];
            end
          end
          iokd_pkg::PORT_FD: res.access_kind = iokd_pkg::ACCESS_WRITE_FD;
          iokd_pkg::PORT_FE: res.access_kind = iokd_pkg::ACCESS_WRITE_FE;
          default:           res.access_kind = iokd_pkg::ACCESS_WRITE_FF;
        endcase
      end
    end
    // The result carries the state as it stands after this item.
    res.chip_register = sound_reg_select_next;
    res.colour_mode   = colour_mode_reg_next;
    res.border_next   = border_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid    <= 1'b0;
      sound_reg_select <= 4'd0;
      colour_mode_reg  <= 6'd0;
      border_pending   <= iokd_pkg::BORDER_RESET;
    end else begin
      if (accept) begin
        m_axis_tvalid    <= 1'b1;
        sound_reg_select <= sound_reg_select_next;
        colour_mode_reg  <= colour_mode_reg_next;
        border_pending   <= border_pending_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res;
    end
  end

  a_chip_write_no_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.chip_write) |->
      (result.access_kind == iokd_pkg::ACCESS_UNCHANGED))
    else $error("sound chip strobe carries an access kind");

  a_colour_enable_mode: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.colour_event == iokd_pkg::COLOUR_ENABLE) |->
      (result.colour_mode != 6'd0 && result.access_kind == iokd_pkg::ACCESS_WRITE_FF))
    else $error("colour enable without a colour mode");

  a_colour_disable_mode: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.colour_event == iokd_pkg::COLOUR_DISABLE) |->
      (result.colour_mode == 6'd0))
    else $error("colour disable leaves a colour mode");

  a_beep_low_on_read: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.beeper_event == iokd_pkg::BEEP_LOW) |->
      (result.access_kind == iokd_pkg::ACCESS_READ_FE))
    else $error("beeper low event outside a keyboard read");

  a_state_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(sound_reg_select) && $stable(colour_mode_reg) &&
                 $stable(border_pending)))
    else $error("decoder state changed without an item");

endmodule

// ----- sim/iokd_result_book_pkg.sv -----
// Result book for the port decoder bench: models the decoder and checks its result items.
`timescale 1ns / 1ps

package iokd_result_book_pkg;

  import iokd_pkg::*;

  class port_result_book;

    // Copy of the configuration registers
    sound_kind_t sound_kind;
    logic        ntsc_mode;
    logic        colour_supported;
    logic [5:0]  ram_kb;
    logic        low_ram;

    // Copy of the decoder state
    logic [3:0]  chip_select;
    logic [5:0]  colour_mode;
    logic [3:0]  border_pending;

    out_fields_t awaited_results[$];
    int          errors;
    int          results_seen;
    int          reads_noted;
    int          writes_noted;

    function new();
      sound_kind       = SOUND_NONE;
      ntsc_mode        = 1'b0;
      colour_supported = 1'b0;
      ram_kb           = RAM_RESET_KB;
      low_ram          = 1'b0;
      chip_select      = '0;
      colour_mode      = '0;
      border_pending   = BORDER_RESET;
      errors           = 0;
      results_seen     = 0;
      reads_noted      = 0;
      writes_noted     = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [5:0] value);
      case (idx)
        CFG_SOUND_KIND:       sound_kind = sound_kind_t'(value[1:0]);
        CFG_NTSC_MODE:        ntsc_mode = value[0];
        CFG_COLOUR_SUPPORTED: colour_supported = value[0];
        CFG_RAM_KILOBYTES:    ram_kb = value;
        CFG_LOW_RAM_ENABLED:  low_ram = value[0];
        default: ;
      endcase
    endfunction

    function out_fields_t decode_access(logic wr, in_fields_t f);
      out_fields_t r;
      logic        beep_on;
      logic        on_colour_port;
      logic        ram_ok;
      logic [7:0]  rows_and;
      logic [7:0]  flip;
      logic [7:0]  mode_bits;
      beep_on = (sound_kind == SOUND_VSYNC_BEEP) ||
                (sound_kind == SOUND_SYNC_BEEP && f.frame_unsynced);
      on_colour_port = (f.port_high == COLOUR_PORT_HIGH) && (f.port_low == COLOUR_PORT_LOW);
      ram_ok = (ram_kb >= COLOUR_MIN_KB) && low_ram;
      r = '0;
      r.read_data    = READ_IDLE;
      r.beeper_event = BEEP_NONE;
      r.access_kind  = ACCESS_UNCHANGED;
      r.colour_event = COLOUR_NONE;
      if (!wr) begin
        if (on_colour_port) begin
          if (ram_ok && colour_supported) r.read_data = COLOUR_PROBE_OK;
        end else if (!f.port_low[0]) begin
          r.access_kind = ACCESS_READ_FE;
          if (beep_on) r.beeper_event = BEEP_LOW;
          flip = TAPE_BIT;
          if (f.tape_active) begin
            flip = (ntsc_mode ? NTSC_BIT : 8'h00) | (f.tape_level ? 8'h00 : TAPE_BIT);
          end
          rows_and = 8'hff;
          // A zero bit in the high address byte selects that keyboard row.
          for (int i = 0; i < 8; i++) begin
            if (!f.port_high[i]) rows_and = rows_and & f.key_rows[8*i +: 8];
          end
          r.read_data = rows_and ^ flip;
        end
      end else begin
        if (beep_on) r.beeper_event = BEEP_HIGH;
        if (on_colour_port) begin
          if (colour_supported) begin
            mode_bits = f.write_data & COLOUR_MODE_MASK;
            if (mode_bits != 8'h00) begin
              if (!ram_ok) begin
                mode_bits = 8'h00;
              end else begin
                r.colour_event = COLOUR_ENABLE;
                border_pending = f.write_data[3:0];
              end
            end else begin
              r.colour_event = COLOUR_DISABLE;
            end
            colour_mode = mode_bits[5:0];
          end
          r.access_kind = ACCESS_WRITE_FF;
        end else begin
          case (f.port_low)
            PORT_CHIP_DATA_A, PORT_CHIP_DATA_B: begin
              if (sound_kind == SOUND_CHIP) begin
                r.chip_write = 1'b1;
                r.chip_data  = f.write_data;
              end
            end
            PORT_CHIP_SEL_A, PORT_CHIP_SEL_B, PORT_CHIP_SEL_C: begin
              if (sound_kind == SOUND_CHIP) chip_select = f.write_data[3:0];
            end
            PORT_FD: r.access_kind = ACCESS_WRITE_FD;
            PORT_FE: r.access_kind = ACCESS_WRITE_FE;
            default: r.access_kind = ACCESS_WRITE_FF;
          endcase
        end
      end
      r.chip_register = chip_select;
      r.colour_mode   = colour_mode;
      r.border_next   = border_pending;
      return r;
    endfunction

    function void note_access(logic wr, in_fields_t f);
      if (wr) writes_noted++;
      else reads_noted++;
      awaited_results.push_back(decode_access(wr, f));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want != seen) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(out_fields_t got);
      out_fields_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result item with nothing awaited, expected none, got %0h", $time, got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("beeper_event", 8'(want.beeper_event), 8'(got.beeper_event));
      compare_field("chip_write", 8'(want.chip_write), 8'(got.chip_write));
      compare_field("chip_register", 8'(want.chip_register), 8'(got.chip_register));
      compare_field("chip_data", want.chip_data, got.chip_data);
      compare_field("access_kind", 8'(want.access_kind), 8'(got.access_kind));
      compare_field("colour_mode", 8'(want.colour_mode), 8'(got.colour_mode));
      compare_field("colour_event", 8'(want.colour_event), 8'(got.colour_event));
      compare_field("border_next", 8'(want.border_next), 8'(got.border_next));
    endfunction

    function void close_out();
      if (awaited_results.size() != 0) begin
        $display("%0t: results still awaited, expected 0, got %0d", $time,
                 awaited_results.size());
        errors++;
      end
    endfunction

  endclass

endpackage

// ----- sim/tb.sv -----
// Bench for the port decoder: directed and random port accesses checked against a model.
`timescale 1ns / 1ps

module tb;

  import iokd_pkg::*;
  import iokd_result_book_pkg::*;

  localparam int CycleLimit = 250000;
  localparam int RandomPhases = 8;
  localparam int ItemsPerPhase = 180;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  cfg_index_t               cfg_index = CFG_SOUND_KIND;
  logic [CfgDataWidth-1:0]  cfg_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InDataWidth-1:0]   s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_axis_tdata;

  port_result_book book = new();
  logic calm = 1'b0;
  int   stall_left = 0;
  int   cycles = 0;
  int   settings_applied = 0;

  io_port_keyboard_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stalls come in bursts of random length, none in the final phase.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        book.check_result(out_fields_t'(m_axis_tdata[$bits(out_fields_t)-1:0]));
      end
      if (s_axis_tvalid && s_axis_tready) begin
        book.note_access(s_axis_tuser, in_fields_t'(s_axis_tdata[$bits(in_fields_t)-1:0]));
      end
      if (cfg_we) book.write_register(cfg_index, cfg_data);
    end
  end

  task automatic send_access(input logic wr, input in_fields_t f);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataWidth - $bits(in_fields_t)){1'b0}}, f};
    s_axis_tuser  <= wr;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic directed(input logic wr, input logic [7:0] hi, input logic [7:0] lo,
                          input logic [7:0] data, input logic [63:0] rows,
                          input logic tape_on, input logic tape_bit, input logic unsynced);
    in_fields_t f;
    f.port_high      = hi;
    f.port_low       = lo;
    f.write_data     = data;
    f.key_rows       = rows;
    f.tape_active    = tape_on;
    f.tape_level     = tape_bit;
    f.frame_unsynced = unsynced;
    send_access(wr, f);
  endtask

  // Wait until every awaited result has been taken, so that the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (book.awaited_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_settings(input sound_kind_t sk, input logic ntsc, input logic colour,
                                input logic [5:0] kb, input logic low);
    logic [5:0] values [5];
    drain();
    values[0] = {4'b0, sk};
    values[1] = {5'b0, ntsc};
    values[2] = {5'b0, colour};
    values[3] = kb;
    values[4] = {5'b0, low};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= values[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Mostly few keys held down, so that row ANDs do not collapse to zero.
  function automatic logic [63:0] random_rows();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 2) != 0) r = r | {$urandom, $urandom} | {$urandom, $urandom};
    return r;
  endfunction

  task automatic random_access();
    in_fields_t f;
    logic       wr;
    int         pick;
    f.port_high      = 8'($urandom_range(0, 255));
    f.port_low       = 8'($urandom_range(0, 255));
    f.write_data     = 8'($urandom_range(0, 255));
    f.key_rows       = random_rows();
    f.tape_active    = 1'($urandom_range(0, 1));
    f.tape_level     = 1'($urandom_range(0, 1));
    f.frame_unsynced = 1'($urandom_range(0, 1));
    wr   = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 15);
    if (pick <= 4) begin
      wr = 1'b0;
      f.port_low = $urandom_range(0, 2) == 0 ? {f.port_low[7:1], 1'b0} : PORT_FE;
      case ($urandom_range(0, 3))
        0: f.port_high = ~(8'h01 << $urandom_range(0, 7));
        1: f.port_high = 8'h00;
        2: f.port_high = 8'hff;
        default: ;
      endcase
    end else if (pick == 5) begin
      wr = 1'b0;
      f.port_low[0] = 1'b1;
    end else if (pick <= 7) begin
      f.port_high = COLOUR_PORT_HIGH;
      f.port_low  = COLOUR_PORT_LOW;
    end else if (pick <= 9) begin
      wr = 1'b1;
      case ($urandom_range(0, 2))
        0: f.port_low = PORT_CHIP_SEL_A;
        1: f.port_low = PORT_CHIP_SEL_B;
        default: f.port_low = PORT_CHIP_SEL_C;
      endcase
    end else if (pick <= 11) begin
      wr = 1'b1;
      f.port_low = $urandom_range(0, 1) ? PORT_CHIP_DATA_A : PORT_CHIP_DATA_B;
    end else if (pick == 12) begin
      wr = 1'b1;
      f.port_low = $urandom_range(0, 1) ? PORT_FD : PORT_FE;
    end
    send_access(wr, f);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Full colour system with the sound chip and NTSC timing.
    apply_settings(SOUND_CHIP, 1'b1, 1'b1, COLOUR_MIN_KB, 1'b1);
    directed(1'b0, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h00, '1, 1'b0, 1'b0, 1'b0);
    directed(1'b0, 8'h00, PORT_FE, 8'h00, '1, 1'b0, 1'b0, 1'b0);
    directed(1'b0, 8'hff, 8'h00, 8'hff, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b0, 8'hfe, PORT_FE, 8'h00, 64'hffff_ffff_ffff_ffe5, 1'b1, 1'b0, 1'b0);
    directed(1'b0, 8'h7f, PORT_FE, 8'h00, 64'hd7ff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b0);
    directed(1'b0, 8'h00, 8'hff, 8'h00, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, 8'hff, PORT_CHIP_SEL_A, 8'hff, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, 8'h00, PORT_CHIP_SEL_B, 8'h00, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, 8'h00, PORT_CHIP_SEL_C, 8'h0a, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, 8'h00, PORT_CHIP_DATA_A, 8'hff, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, 8'hff, PORT_CHIP_DATA_B, 8'h00, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h3f, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h15, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h00, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, 8'h00, PORT_FD, 8'h55, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b1, 8'h00, PORT_FE, 8'haa, '0, 1'b1, 1'b1, 1'b1);
    directed(1'b1, 8'hff, 8'h00, 8'h00, '1, 1'b1, 1'b1, 1'b1);

    // One kilobyte short of what the colour interface needs.
    apply_settings(SOUND_VSYNC_BEEP, 1'b0, 1'b1, COLOUR_MIN_KB - 6'd1, 1'b1);
    directed(1'b0, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h00, '1, 1'b0, 1'b0, 1'b0);
    directed(1'b1, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h20, '0, 1'b0, 1'b0, 1'b0);
    directed(1'b0, 8'hbf, PORT_FE, 8'h00, 64'h00fe_ffff_ffff_ffff, 1'b1, 1'b0, 1'b0);
    directed(1'b1, 8'h00, PORT_CHIP_SEL_A, 8'h07, '0, 1'b0, 1'b0, 1'b0);

    // Colour interface unsupported; the beeper follows frame sync.
    apply_settings(SOUND_SYNC_BEEP, 1'b0, 1'b0, COLOUR_MIN_KB, 1'b1);
    directed(1'b1, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h30, '0, 1'b0, 1'b0, 1'b1);
    directed(1'b0, COLOUR_PORT_HIGH, COLOUR_PORT_LOW, 8'h00, '1, 1'b0, 1'b0, 1'b1);
    directed(1'b0, 8'hef, PORT_FE, 8'h00, 64'hffff_ff3c_ffff_ffff, 1'b0, 1'b0, 1'b1);
    directed(1'b1, 8'h00, PORT_FD, 8'h00, '0, 1'b0, 1'b0, 1'b0);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: apply_settings(SOUND_CHIP, 1'b1, 1'b1, COLOUR_MIN_KB, 1'b1);
        1: apply_settings(SOUND_NONE, 1'b0, 1'b0, 6'd1, 1'b0);
        2: apply_settings(SOUND_SYNC_BEEP, 1'b1, 1'b1, COLOUR_MIN_KB, 1'b0);
        3: apply_settings(SOUND_VSYNC_BEEP, 1'b0, 1'b1, COLOUR_MIN_KB - 6'd1, 1'b1);
        RandomPhases - 1: begin
          apply_settings(SOUND_CHIP, 1'b0, 1'b1, COLOUR_MIN_KB, 1'b1);
          calm = 1'b1;
        end
        default: apply_settings(sound_kind_t'($urandom_range(0, 3)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                6'($urandom_range(40, 48)), 1'($urandom_range(0, 1)));
      endcase
      repeat (ItemsPerPhase) random_access();
    end

    drain();
    repeat (5) @(posedge clk);
    book.close_out();
    $display("Checked %0d result items from %0d reads and %0d writes.",
             book.results_seen, book.reads_noted, book.writes_noted);
    $display("Register settings applied: %0d, with random stalls on both sides until the last.",
             settings_applied);
    if (book.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/iokd_pkg.sv
src/io_port_keyboard_decoder_top.sv
sim/iokd_result_book_pkg.sv
sim/tb.sv
